// File: rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared constants for the frame checker / deframer
// Frame layout sizes, CRC-16 polynomial, seed reset value and status codes.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned HDR_BYTES     = 18;
    localparam int unsigned TRAILER_BYTES = 2;
    localparam int unsigned MAX_PAYLOAD   = 256;

    localparam int unsigned POS_W      = 17;
    localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES);

    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;

    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_SHORT        = 3'd1;
    localparam logic [2:0] STATUS_TOO_LONG     = 3'd2;
    localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd3;
    localparam logic [2:0] STATUS_CRC_MISMATCH = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

endpackage

// File: rtl/core/cfd_ifs.sv
// ----------------------------------------------------------------------------
// cfd channel interfaces
// Valid/ready channels for frame bytes, frame results and the seed register.
// ----------------------------------------------------------------------------
interface cfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface cfd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [7:0]  start_byte;
    logic [7:0]  version;
    logic [7:0]  message_type;
    logic [7:0]  flags_byte;
    logic [15:0] node_id;
    logic [15:0] seq_number;
    logic [63:0] timestamp;
    logic [15:0] payload_length;
    logic [15:0] crc_value;

    modport source (
        output valid, output kind, output data_byte, output status,
        output start_byte, output version, output message_type, output flags_byte,
        output node_id, output seq_number, output timestamp, output payload_length,
        output crc_value, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input status,
        input start_byte, input version, input message_type, input flags_byte,
        input node_id, input seq_number, input timestamp, input payload_length,
        input crc_value, output ready
    );
endinterface

interface cfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] crc_seed;

    modport source (output valid, output crc_seed, input ready);
    modport sink   (input valid, input crc_seed, output ready);
endinterface

// File: rtl/core/crc_frame_checker_deframer.sv
// ----------------------------------------------------------------------------
// crc_frame_checker_deframer: length-prefixed frame checker with CRC-16
// Passes payload bytes on and reports one status result per frame.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------
//  frame   | in  | valid/ready | rx_byte, end_of_frame
//  result  | out | valid/ready | kind, data_byte, status, header fields, crc
//  cfg     | in  | valid/ready | crc_seed (always ready)
//
//  One byte transfer per cycle sustained unless the result channel stalls.
//  Each byte passes an input register; a byte that makes a result then loads the result register.
//  The per-byte path is one CRC byte update plus the status compares.
//  A stalled result holds in the result register; the input register keeps
//  accepting while the byte in it causes no result or the result slot frees.
//  rst_n clears position, header capture, CRC trailer window and seed to
//  their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module crc_frame_checker_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    cfd_frame_if.sink   frame,
    cfd_result_if.source result,
    cfd_cfg_if.sink     cfg
);
    import cfd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [7:0]  start_byte;
        logic [7:0]  version;
        logic [7:0]  message_type;
        logic [7:0]  flags_byte;
        logic [15:0] node_id;
        logic [15:0] seq_number;
        logic [63:0] timestamp;
        logic [15:0] payload_length;
        logic [15:0] crc_value;
    } res_t;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Seed register
    logic [15:0] seed_reg;

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eof_reg;

    // Frame state
    logic [POS_W-1:0] pos_reg;
    logic [15:0]      crc_accum_reg;
    logic [15:0]      crc_rx_reg;
    logic [7:0]       hdr_reg [HDR_BYTES];

    // Result register
    logic out_valid_reg;
    res_t out_reg;

    // Per-byte logic
    logic [7:0]   hdr_next [HDR_BYTES];
    logic [15:0]  crc_rx_next;
    logic [15:0]  crc_base;
    logic [15:0]  crc_calc;
    logic [15:0]  crc_next;
    logic         crc_step;
    logic [15:0]  len_cur;
    logic [15:0]  len_next;
    logic [POS_W:0] total;
    logic         in_payload;
    logic         has_result;
    logic         out_free;
    logic         s1_fire;
    logic [2:0]   status_calc;
    res_t         res_calc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= CRC_SEED_RESET;
        end
        else if (cfg.valid)
        begin
            seed_reg <= cfg.crc_seed;
        end
    end

    // Capture the current header byte so the status sees this byte too.
    always_comb
    begin
        hdr_next = hdr_reg;
        if (pos_reg < POS_W'(HDR_BYTES))
        begin
            hdr_next[pos_reg[HDR_IDX_W-1:0]] = s1_byte_reg;
        end
    end

    // Trailer window: the last two bytes, older one in the low half.
    assign crc_rx_next = {s1_byte_reg, crc_rx_reg[15:8]};

    // The CRC runs two bytes behind so the trailer never enters it; the
    // seed is taken when the first byte goes in, at the third frame byte.
    assign crc_step = (pos_reg >= POS_W'(2));
    assign crc_base = (pos_reg == POS_W'(2)) ? seed_reg : crc_accum_reg;

    cfd_crc16 u_crc
    (
        .crc_in  (crc_base),
        .data    (crc_rx_reg[7:0]),
        .crc_out (crc_calc)
    );

    assign crc_next = crc_step ? crc_calc : crc_accum_reg;

    assign len_cur  = {hdr_reg[HDR_BYTES-1], hdr_reg[HDR_BYTES-2]};
    assign len_next = {hdr_next[HDR_BYTES-1], hdr_next[HDR_BYTES-2]};
    assign total    = {1'b0, pos_reg} + (POS_W+1)'(1);

    assign in_payload = (pos_reg >= POS_W'(HDR_BYTES)) &&
                        ({1'b0, pos_reg} < ((POS_W+1)'(HDR_BYTES) + (POS_W+1)'(len_cur)));

    // Checks in priority order: short, too long, length, CRC.
    always_comb
    begin
        if (total < (POS_W+1)'(HDR_BYTES + TRAILER_BYTES))
        begin
            status_calc = STATUS_SHORT;
        end
        else if ({1'b0, len_next} > 17'(MAX_PAYLOAD))
        begin
            status_calc = STATUS_TOO_LONG;
        end
        else if (total != ((POS_W+1)'(HDR_BYTES + TRAILER_BYTES) + (POS_W+1)'(len_next)))
        begin
            status_calc = STATUS_LEN_MISMATCH;
        end
        else if (crc_next != crc_rx_next)
        begin
            status_calc = STATUS_CRC_MISMATCH;
        end
        else
        begin
            status_calc = STATUS_OK;
        end
    end

    always_comb
    begin
        res_calc = '0;
        if (s1_eof_reg)
        begin
            res_calc.kind           = KIND_STATUS;
            res_calc.status         = status_calc;
            res_calc.start_byte     = hdr_next[0];
            res_calc.version        = hdr_next[1];
            res_calc.message_type   = hdr_next[2];
            res_calc.flags_byte     = hdr_next[3];
            res_calc.node_id        = {hdr_next[5], hdr_next[4]};
            res_calc.seq_number     = {hdr_next[7], hdr_next[6]};
            res_calc.timestamp      = {hdr_next[15], hdr_next[14], hdr_next[13],
                                       hdr_next[12], hdr_next[11], hdr_next[10],
                                       hdr_next[9], hdr_next[8]};
            res_calc.payload_length = len_next;
            res_calc.crc_value      = crc_rx_next;
        end
        else
        begin
            res_calc.kind      = KIND_PAYLOAD;
            res_calc.data_byte = s1_byte_reg;
        end
    end

    // Advance the input register unless its result would overwrite a stalled one.
    assign has_result   = s1_eof_reg || in_payload;
    assign out_free     = !out_valid_reg || result.ready;
    assign s1_fire      = s1_valid_reg && (!has_result || out_free);
    assign frame.ready  = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            s1_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.ready && frame.valid)
        begin
            s1_byte_reg <= frame.rx_byte;
            s1_eof_reg  <= frame.end_of_frame;
        end
    end

    // Frame state: update per byte, drop back to start values at frame end (CRC accumulator takes the seed).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_accum_reg <= CRC_SEED_RESET;
            crc_rx_reg    <= '0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            if (s1_eof_reg)
            begin
                pos_reg       <= '0;
                crc_accum_reg <= seed_reg;
                crc_rx_reg    <= '0;
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    hdr_reg[i] <= '0;
                end
            end
            else
            begin
                if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                crc_accum_reg <= crc_next;
                crc_rx_reg    <= crc_rx_next;
                hdr_reg       <= hdr_next;
            end
        end
    end

    // Result register: hold while stalled, load when a result is produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_reg <= res_calc;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_reg.kind;
    assign result.data_byte      = out_reg.data_byte;
    assign result.status         = out_reg.status;
    assign result.start_byte     = out_reg.start_byte;
    assign result.version        = out_reg.version;
    assign result.message_type   = out_reg.message_type;
    assign result.flags_byte     = out_reg.flags_byte;
    assign result.node_id        = out_reg.node_id;
    assign result.seq_number     = out_reg.seq_number;
    assign result.timestamp      = out_reg.timestamp;
    assign result.payload_length = out_reg.payload_length;
    assign result.crc_value      = out_reg.crc_value;

endmodule

// File: rtl/core/cfd_crc16.sv
// ----------------------------------------------------------------------------
// cfd_crc16: one-byte CRC-16 update
// MSB-first, non-reflected CRC over one byte, eight bit steps.
// ----------------------------------------------------------------------------
module cfd_crc16
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import cfd_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule
